/* sv/kvp_pkg.sv */
package kvp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned VerbMax = 6;
  localparam int unsigned VerbW  = ByteW * VerbMax;

  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_TAB   = 8'h09;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
  localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
  localparam logic [ByteW-1:0] CH_LC_A  = 8'h61;
  localparam logic [ByteW-1:0] CH_LC_Z  = 8'h7A;
  localparam logic [ByteW-1:0] CASE_OFS = 8'h20;

  // verbs, first character in the low byte
  localparam logic [VerbW-1:0] VERB_PUT    = 48'h0000_0054_5550;
  localparam logic [VerbW-1:0] VERB_GET    = 48'h0000_0054_4547;
  localparam logic [VerbW-1:0] VERB_DEL    = 48'h0000_004C_4544;
  localparam logic [VerbW-1:0] VERB_DELETE = 48'h4554_454C_4544;
  localparam logic [VerbW-1:0] VERB_EXISTS = 48'h5354_5349_5845;
  localparam logic [VerbW-1:0] VERB_SIZE   = 48'h0000_455A_4953;

  localparam logic [2:0] LEN_3   = 3'd3;
  localparam logic [2:0] LEN_4   = 3'd4;
  localparam logic [2:0] LEN_6   = 3'd6;
  localparam logic [2:0] LEN_SAT = 3'd7;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_VERB   = 3'd1,
    PH_PREKEY = 3'd2,
    PH_KEY    = 3'd3,
    PH_AFTER  = 3'd4,
    PH_IGNORE = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    CMD_PUT     = 3'd0,
    CMD_GET     = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_EXISTS  = 3'd3,
    CMD_SIZE    = 3'd4,
    CMD_UNKNOWN = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_PUT_ARGS    = 3'd1,
    ST_GET_ARGS    = 3'd2,
    ST_DELETE_ARGS = 3'd3,
    ST_EXISTS_ARGS = 3'd4,
    ST_SIZE_ARGS   = 3'd5,
    ST_UNKNOWN     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_KEY   = 2'd1,
    KIND_VALUE = 2'd2
  } kind_t;

  typedef struct packed {
    logic            valid;
    logic [ByteW-1:0] data_byte;
    kind_t           data_kind;
    logic            line_done;
    cmd_t            command;
    status_t         status;
  } res_t;

  function automatic logic is_ws(input logic [ByteW-1:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic cmd_t match_verb(input logic [VerbW-1:0] chars, input logic [2:0] len);
    cmd_t c;
    c = CMD_UNKNOWN;
    if (len == LEN_3 && chars == VERB_PUT) c = CMD_PUT;
    else if (len == LEN_3 && chars == VERB_GET) c = CMD_GET;
    else if (len == LEN_6 && chars == VERB_DELETE) c = CMD_DELETE;
    else if (len == LEN_3 && chars == VERB_DEL) c = CMD_DELETE;
    else if (len == LEN_6 && chars == VERB_EXISTS) c = CMD_EXISTS;
    else if (len == LEN_4 && chars == VERB_SIZE) c = CMD_SIZE;
    return c;
  endfunction

  function automatic phase_t phase_after_verb(input cmd_t c);
    phase_t p;
    if (c == CMD_UNKNOWN) p = PH_IGNORE;
    else if (c == CMD_SIZE) p = PH_AFTER;
    else p = PH_PREKEY;
    return p;
  endfunction

endpackage

/* sv/kvp_parse.sv */
module kvp_parse
  import kvp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             consume,
  input  logic [ByteW-1:0] in_byte,
  input  logic             in_eol,
  output res_t             res
);

  phase_t           phase_r, phase_nxt;
  logic [VerbW-1:0] chars_r, chars_nxt;
  logic [2:0]       len_r, len_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic             key_r, key_nxt;
  logic             value_r, value_nxt;
  logic             extra_r, extra_nxt;

  logic             ws;
  logic [ByteW-1:0] up_byte;
  logic [VerbW-1:0] add_chars;
  logic [2:0]       add_len;
  logic             val_cand;
  kind_t            kind;
  cmd_t             cmd_eol;
  status_t          st;

  assign ws = is_ws(in_byte);
  assign up_byte = (in_byte >= CH_LC_A && in_byte <= CH_LC_Z) ? in_byte - CASE_OFS : in_byte;

  always_comb begin
    add_chars = chars_r;
    for (int i = 0; i < VerbMax; i++) begin
      if (len_r == 3'(i)) add_chars[i*ByteW +: ByteW] = up_byte;
    end
    add_len = (len_r < LEN_SAT) ? len_r + 3'd1 : len_r;
  end

  always_comb begin
    phase_nxt = phase_r;
    chars_nxt = chars_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    extra_nxt = extra_r;
    val_cand  = 1'b0;
    kind      = KIND_NONE;
    unique case (phase_r)
      PH_LEAD: begin
        if (!ws) begin
          chars_nxt = add_chars;
          len_nxt   = add_len;
          phase_nxt = PH_VERB;
        end
      end
      PH_VERB: begin
        if (ws) begin
          cmd_nxt   = match_verb(chars_r, len_r);
          phase_nxt = phase_after_verb(cmd_nxt);
        end else begin
          chars_nxt = add_chars;
          len_nxt   = add_len;
        end
      end
      PH_PREKEY: begin
        if (!ws) begin
          kind      = KIND_KEY;
          key_nxt   = 1'b1;
          phase_nxt = PH_KEY;
        end
      end
      PH_KEY: begin
        if (ws) begin
          phase_nxt = PH_AFTER;
          if (cmd_r == CMD_PUT) begin
            if (in_byte == CH_LF) phase_nxt = PH_IGNORE;
            else if (in_byte != CH_SPACE) val_cand = 1'b1;
          end
        end else begin
          kind = KIND_KEY;
        end
      end
      PH_AFTER: begin
        if (cmd_r == CMD_PUT) begin
          if (in_byte == CH_LF) phase_nxt = PH_IGNORE;
          else val_cand = 1'b1;
        end else if (!ws) begin
          extra_nxt = 1'b1;
          phase_nxt = PH_IGNORE;
        end
      end
      default: ;
    endcase

    // a final carriage return never counts as value content
    if (val_cand && !(in_byte == CH_CR && in_eol)) begin
      kind      = KIND_VALUE;
      value_nxt = 1'b1;
    end

    cmd_eol = (phase_nxt == PH_VERB) ? match_verb(chars_nxt, len_nxt) : cmd_nxt;
    unique case (cmd_eol)
      CMD_PUT:    st = (key_nxt && value_nxt) ? ST_OK : ST_PUT_ARGS;
      CMD_GET:    st = (key_nxt && !extra_nxt) ? ST_OK : ST_GET_ARGS;
      CMD_DELETE: st = (key_nxt && !extra_nxt) ? ST_OK : ST_DELETE_ARGS;
      CMD_EXISTS: st = (key_nxt && !extra_nxt) ? ST_OK : ST_EXISTS_ARGS;
      CMD_SIZE:   st = extra_nxt ? ST_SIZE_ARGS : ST_OK;
      default:    st = ST_UNKNOWN;
    endcase

    res.valid     = (kind != KIND_NONE) || in_eol;
    res.data_byte = (kind != KIND_NONE) ? in_byte : '0;
    res.data_kind = kind;
    res.line_done = in_eol;
    res.status    = in_eol ? st : ST_OK;
    res.command   = (in_eol && st == ST_OK) ? cmd_eol : CMD_PUT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (consume && in_eol)) begin
      phase_r <= PH_LEAD;
      chars_r <= '0;
      len_r   <= '0;
      cmd_r   <= CMD_UNKNOWN;
      key_r   <= 1'b0;
      value_r <= 1'b0;
      extra_r <= 1'b0;
    end else if (consume) begin
      phase_r <= phase_nxt;
      chars_r <= chars_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      key_r   <= key_nxt;
      value_r <= value_nxt;
      extra_r <= extra_nxt;
    end
  end

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    consume && in_eol |=> phase_r == PH_LEAD && len_r == '0)
    else $error("parser state not cleared after end of line");

  a_lead_empty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LEAD |-> len_r == '0 && !key_r && !value_r && !extra_r)
    else $error("leftover state before verb");

  a_key_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_KEY |-> key_r && cmd_r != CMD_UNKNOWN)
    else $error("key phase without command");

endmodule

/* sv/kvp_out_reg.sv */
module kvp_out_reg
  import kvp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  res_t  res_in,
  input  logic  out_tready,
  output logic  out_valid,
  output res_t  res_out,
  output logic  can_load
);

  logic out_valid_r;
  res_t res_r;

  assign can_load  = !out_valid_r || out_tready;
  assign out_valid = out_valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res_in;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load)
    else $error("held result overwritten");

  a_cmd_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.status != ST_OK |-> res_r.command == CMD_PUT)
    else $error("command given with failing status");

  a_kind_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.data_kind == KIND_NONE |-> res_r.data_byte == '0 && res_r.line_done)
    else $error("empty result without verdict");

endmodule

/* sv/kv_command_line_parser_core.sv */
// Path: one input register feeds the parser, whose result is held in the output register.
// Throughput: 1 word per cycle while out_tready is high; a held result stalls the input.
// Reset: synchronous, active low; clears valids and parser state (idle, no verb).
// Every line ending word yields a verdict word; other words yield one only for key/value data.
module kv_command_line_parser_core
  import kvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] line_byte
  input  logic        in_tlast,   // end_of_line
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [10:8] command, [13:11] status, zero pad
  output logic [1:0]  out_tuser,  // [1:0] data_kind
  output logic        out_tlast   // line_done
);

  logic             s1_valid_r;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_eol_r;
  logic             can_load;
  logic             consume;
  res_t             res;
  res_t             res_q;

  assign consume   = s1_valid_r && can_load;
  assign in_tready = !s1_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_eol_r  <= in_tlast;
    end
  end

  kvp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .consume (consume),
    .in_byte (s1_byte_r),
    .in_eol  (s1_eol_r),
    .res     (res)
  );

  kvp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (consume && res.valid),
    .res_in     (res),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .res_out    (res_q),
    .can_load   (can_load)
  );

  assign out_tdata = {2'b00, res_q.status, res_q.command, res_q.data_byte};
  assign out_tuser = res_q.data_kind;
  assign out_tlast = res_q.line_done;

endmodule

/* verif/tb_kv_command_line_parser_core.sv */
module tb_kv_command_line_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import kvp_pkg::*;

  typedef logic [7:0] line_t[$];

  class kv_line_scoreboard;
    typedef struct {
      logic [7:0] data_byte;
      kind_t      kind;
      logic       done;
      cmd_t       cmd;
      status_t    st;
    } parse_word_t;

    parse_word_t expected_words[$];

    phase_t      phase      = PH_LEAD;
    logic [47:0] verb_text  = '0;
    logic [2:0]  verb_cnt   = '0;
    cmd_t        verb_cmd   = CMD_UNKNOWN;
    logic        have_key   = 1'b0;
    logic        have_value = 1'b0;
    logic        have_extra = 1'b0;

    int errors    = 0;
    int key_cnt   = 0;
    int value_cnt = 0;
    int verdicts  = 0;
    int st_seen[7];

    function void clear_line();
      phase      = PH_LEAD;
      verb_text  = '0;
      verb_cnt   = '0;
      verb_cmd   = CMD_UNKNOWN;
      have_key   = 1'b0;
      have_value = 1'b0;
      have_extra = 1'b0;
    endfunction

    function void push_verb(logic [7:0] b);
      if (b >= CH_LC_A && b <= CH_LC_Z) b = b - CASE_OFS;
      if (verb_cnt < LEN_6) verb_text[int'(verb_cnt)*8 +: 8] = b;
      if (verb_cnt != LEN_SAT) verb_cnt = verb_cnt + 3'd1;
    endfunction

    function cmd_t verb_command();
      case (verb_cnt)
        LEN_3: begin
          if (verb_text == VERB_PUT) return CMD_PUT;
          if (verb_text == VERB_GET) return CMD_GET;
          if (verb_text == VERB_DEL) return CMD_DELETE;
        end
        LEN_4: begin
          if (verb_text == VERB_SIZE) return CMD_SIZE;
        end
        LEN_6: begin
          if (verb_text == VERB_DELETE) return CMD_DELETE;
          if (verb_text == VERB_EXISTS) return CMD_EXISTS;
        end
        default: ;
      endcase
      return CMD_UNKNOWN;
    endfunction

    function void note_byte(logic [7:0] b, logic eol);
      logic        blank;
      logic        val_cand;
      parse_word_t w;
      blank    = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
      val_cand = 1'b0;
      w.data_byte = 8'h00;
      w.kind      = KIND_NONE;
      w.done      = 1'b0;
      w.cmd       = CMD_PUT;
      w.st        = ST_OK;
      case (phase)
        PH_LEAD: begin
          if (!blank) begin
            push_verb(b);
            phase = PH_VERB;
          end
        end
        PH_VERB: begin
          if (blank) begin
            verb_cmd = verb_command();
            if (verb_cmd == CMD_UNKNOWN) phase = PH_IGNORE;
            else if (verb_cmd == CMD_SIZE) phase = PH_AFTER;
            else phase = PH_PREKEY;
          end else begin
            push_verb(b);
          end
        end
        PH_PREKEY: begin
          if (!blank) begin
            w.kind   = KIND_KEY;
            have_key = 1'b1;
            phase    = PH_KEY;
          end
        end
        PH_KEY: begin
          if (blank) begin
            phase = PH_AFTER;
            if (verb_cmd == CMD_PUT) begin
              if (b == CH_LF) phase = PH_IGNORE;
              else if (b != CH_SPACE) val_cand = 1'b1;
            end
          end else begin
            w.kind = KIND_KEY;
          end
        end
        PH_AFTER: begin
          if (verb_cmd == CMD_PUT) begin
            if (b == CH_LF) phase = PH_IGNORE;
            else val_cand = 1'b1;
          end else if (!blank) begin
            have_extra = 1'b1;
            phase      = PH_IGNORE;
          end
        end
        default: ;
      endcase
      // trailing CR never counts as value content
      if (val_cand && !(b == CH_CR && eol)) begin
        w.kind     = KIND_VALUE;
        have_value = 1'b1;
      end
      if (eol) begin
        if (phase == PH_VERB) verb_cmd = verb_command();
        w.done = 1'b1;
        case (verb_cmd)
          CMD_PUT:    w.st = (have_key && have_value) ? ST_OK : ST_PUT_ARGS;
          CMD_GET:    w.st = (have_key && !have_extra) ? ST_OK : ST_GET_ARGS;
          CMD_DELETE: w.st = (have_key && !have_extra) ? ST_OK : ST_DELETE_ARGS;
          CMD_EXISTS: w.st = (have_key && !have_extra) ? ST_OK : ST_EXISTS_ARGS;
          CMD_SIZE:   w.st = have_extra ? ST_SIZE_ARGS : ST_OK;
          default:    w.st = ST_UNKNOWN;
        endcase
        if (w.st == ST_OK) w.cmd = verb_cmd;
        clear_line();
      end
      if (w.kind != KIND_NONE) w.data_byte = b;
      if (w.kind != KIND_NONE || w.done) expected_words.push_back(w);
    endfunction

    function void mismatch(string field, logic [15:0] exp_v, logic [15:0] got_v);
      $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, got_v);
      errors++;
    endfunction

    function void check_word(logic [15:0] tdata, logic [1:0] tuser, logic tlast);
      parse_word_t w;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: tdata 0x%0h tuser %0d tlast %0b",
               tdata, tuser, tlast);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (tdata[7:0] !== w.data_byte)
        mismatch("data_byte", 16'(w.data_byte), 16'(tdata[7:0]));
      if (tuser !== w.kind) mismatch("data_kind", 16'(w.kind), 16'(tuser));
      if (tlast !== w.done) mismatch("line_done", 16'(w.done), 16'(tlast));
      if (tdata[10:8] !== w.cmd) mismatch("command", 16'(w.cmd), 16'(tdata[10:8]));
      if (tdata[13:11] !== w.st) mismatch("status", 16'(w.st), 16'(tdata[13:11]));
      if (tdata[15:14] !== 2'b00) mismatch("pad", 16'h0000, 16'(tdata[15:14]));
      if (w.kind == KIND_KEY) key_cnt++;
      if (w.kind == KIND_VALUE) value_cnt++;
      if (w.done) begin
        verdicts++;
        st_seen[int'(w.st)]++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  kv_line_scoreboard sb = new;

  int    in_max_gap    = 0;
  int    out_max_stall = 0;
  int    hold_req      = 0;
  int    n_bytes       = 0;
  int    n_lines       = 0;
  string verbs[6]      = '{"PUT", "GET", "DEL", "DELETE", "EXISTS", "SIZE"};

  kv_command_line_parser_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser, out_tlast);
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int stall;
    out_tready <= 1'b0;
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = $urandom_range(out_max_stall, 0);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_tvalid));
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("** kv_command_line_parser_core: FAILED **");
    $finish;
  end

  function automatic logic [7:0] blank_byte();
    int r;
    r = $urandom_range(5, 0);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  function automatic logic [7:0] nonblank_byte(input bit any_val);
    logic [7:0] b;
    do begin
      b = any_val ? 8'($urandom_range(255, 0)) : 8'($urandom_range(8'h7E, 8'h21));
    end while (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR));
    return b;
  endfunction

  function automatic void add_text(ref line_t q, input string s, input bit mix);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix && c >= 8'h41 && c <= 8'h5A && $urandom_range(1, 0) == 1) c = c + CASE_OFS;
      q.push_back(c);
    end
  endfunction

  function automatic void make_line(ref line_t q);
    int pick;
    int sel;
    int n;
    bit is_put;
    bit is_size;
    q.delete();
    pick = $urandom_range(99, 0);
    if (pick < 15) begin
      n = $urandom_range(12, 1);
      repeat (n) q.push_back(8'($urandom_range(255, 0)));
      return;
    end
    if ($urandom_range(3, 0) == 0) q.push_back(blank_byte());
    sel = $urandom_range(7, 0);
    if (sel < 6) begin
      add_text(q, verbs[sel], 1'b1);
    end else if (sel == 6) begin
      if ($urandom_range(1, 0) == 1) add_text(q, verbs[$urandom_range(5, 0)], 1'b1);
      n = $urandom_range(9, 1);
      repeat (n) q.push_back(nonblank_byte(1'b0));
    end else begin
      add_text(q, "PUT", 1'b1);
    end
    is_put  = (sel == 0 || sel == 7);
    is_size = (sel == 5);
    if ($urandom_range(15, 0) == 0) return;
    n = $urandom_range(2, 1);
    repeat (n) q.push_back(blank_byte());
    if (!is_size || $urandom_range(3, 0) == 0) begin
      n = $urandom_range(6, 1);
      repeat (n) q.push_back(nonblank_byte($urandom_range(4, 0) == 0));
    end
    if (is_put) begin
      pick = $urandom_range(9, 0);
      if (pick < 6) q.push_back(CH_SPACE);
      else if (pick < 9) q.push_back(blank_byte());
      n = $urandom_range(10, 0);
      repeat (n) begin
        pick = $urandom_range(19, 0);
        q.push_back(pick == 0 ? 8'($urandom_range(255, 0)) :
                    (pick < 3 ? CH_SPACE : nonblank_byte(1'b0)));
      end
      if ($urandom_range(2, 0) == 0) q.push_back(CH_CR);
    end else begin
      if ($urandom_range(4, 0) == 0) begin
        q.push_back(blank_byte());
        n = $urandom_range(4, 1);
        repeat (n) q.push_back(nonblank_byte(1'b0));
      end
      if ($urandom_range(4, 0) == 0) q.push_back(blank_byte());
    end
    // cut the line short now and then
    if ($urandom_range(9, 0) == 0) begin
      n = $urandom_range(q.size(), 1);
      q = q[0:n-1];
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eol);
    int gap;
    gap = $urandom_range(in_max_gap, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eol;
    do @(posedge clk); while (!in_tready);
    n_bytes++;
  endtask

  task automatic send_line(input line_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    n_lines++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin : main
    line_t q;
    int    line_no;
    int    rnd_base;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed lines
    in_max_gap    = 1;
    out_max_stall = 1;
    q = {};
    add_text(q, "put ", 1'b0);
    q.push_back(8'hFF);
    q.push_back(CH_SPACE);
    q.push_back(8'h00);
    q.push_back(CH_CR);
    q.push_back(CH_LF);
    q.push_back(CH_CR);
    send_line(q);
    q = {};
    add_text(q, "PUT k", 1'b0);
    q.push_back(8'h0B);
    add_text(q, "x", 1'b0);
    q.push_back(CH_CR);
    send_line(q);
    q = {};
    add_text(q, "Put k", 1'b0);
    q.push_back(CH_LF);
    send_line(q);
    q = {}; add_text(q, "put k", 1'b0); send_line(q);
    q = {}; add_text(q, "get k", 1'b0); send_line(q);
    q = {}; add_text(q, "DEL k x", 1'b0); send_line(q);
    q = {};
    add_text(q, " delete", 1'b0);
    q.push_back(CH_TAB);
    add_text(q, "k ", 1'b0);
    send_line(q);
    q = {}; add_text(q, "exists", 1'b0); send_line(q);
    q = {}; add_text(q, "EXISTS k", 1'b0); send_line(q);
    q = {}; add_text(q, "size", 1'b0); send_line(q);
    q = {}; add_text(q, "SIZE 1", 1'b0); send_line(q);
    q = {}; add_text(q, "deletes k", 1'b0); send_line(q);
    q = {}; q.push_back(CH_TAB); send_line(q);
    drain();

    // random lines
    rnd_base = n_bytes;
    line_no  = 0;
    while (n_bytes - rnd_base < 965) begin
      if (line_no % 10 == 0) begin
        in_max_gap    = ($urandom_range(3, 0) == 0) ? 0 : 4;
        out_max_stall = ($urandom_range(3, 0) == 0) ? 0 : 4;
      end
      if (line_no == 20) hold_req = 300;
      if (line_no == 45) drain();
      make_line(q);
      send_line(q);
      line_no++;
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Ran %0d lines, %0d bytes: %0d key bytes, %0d value bytes, %0d verdicts checked",
             n_lines, n_bytes, sb.key_cnt, sb.value_cnt, sb.verdicts);
    $display("Verdicts ok/put/get/delete/exists/size/unknown: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             sb.st_seen[0], sb.st_seen[1], sb.st_seen[2], sb.st_seen[3],
             sb.st_seen[4], sb.st_seen[5], sb.st_seen[6]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** kv_command_line_parser_core: PASSED **");
    end else begin
      $display("** kv_command_line_parser_core: FAILED **");
    end
    $finish;
  end

endmodule

/* kv_command_line_parser_core.f */
sv/kvp_pkg.sv
sv/kvp_parse.sv
sv/kvp_out_reg.sv
sv/kv_command_line_parser_core.sv
verif/tb_kv_command_line_parser_core.sv
